>>> hw/rtl/lbrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbrc_pkg
// Shared widths, codes and types of the block read cache tag keeper.
// ----------------------------------------------------------------------------
package lbrc_pkg;

  // field widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 40;
  localparam int LEN_W    = 31;
  localparam int STAT_W   = 3;
  localparam int BIDX_W   = 2;
  localparam int OFFS_W   = 20;
  localparam int CNT_W    = 21;
  localparam int TAG_W    = 36;
  localparam int LG_W     = 5;
  localparam int SLOTS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 40;

  // default slot count
  localparam int NSLOTS_DEF = 4;

  // block size limits and reset values
  localparam logic [LG_W-1:0]    LG_MIN      = 5'd4;
  localparam logic [LG_W-1:0]    LG_MAX      = 5'd20;
  localparam logic [LG_W-1:0]    LG_RESET    = 5'd15;
  localparam logic [POS_W-1:0]   FSIZE_RESET = '0;
  localparam logic [SLOTS_W-1:0] SLOTS_RESET = 3'd4;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL   = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS      = 2'd2;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_HIT         = 3'd0,
    ST_MISS        = 3'd1,
    ST_EOF         = 3'd2,
    ST_FILLED      = 3'd3,
    ST_INVALIDATED = 3'd4
  } status_t;

  // per-cell update controls
  typedef struct packed {
    logic take;     // load from neighbor
    logic set_tag;  // mark valid with the new block number
    logic clear;    // empty the slot
  } cell_ctl_t;

endpackage

>>> hw/rtl/lbrc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbrc_cell
// One slot of the recency chain: valid, tag and buffer, with a tag compare.
// ----------------------------------------------------------------------------
module lbrc_cell
  import lbrc_pkg::*;
#(
  parameter int BUF_W     = 2,
  parameter int RESET_BUF = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [TAG_W-1:0] key,
  input  logic             nb_valid,
  input  logic [TAG_W-1:0] nb_tag,
  input  logic [BUF_W-1:0] nb_bufn,
  output logic             valid,
  output logic [TAG_W-1:0] tag,
  output logic [BUF_W-1:0] bufn,
  output logic             match
);

  logic             valid_r;
  logic [TAG_W-1:0] tag_r;
  logic [BUF_W-1:0] bufn_r;

  // valid bit and buffer number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      bufn_r  <= BUF_W'(RESET_BUF);
    end else begin
      if (ctl.take) bufn_r <= nb_bufn;
      // clear wins over a new tag, which wins over the neighbor's bit
      if (ctl.clear) begin
        valid_r <= 1'b0;
      end else if (ctl.set_tag) begin
        valid_r <= 1'b1;
      end else if (ctl.take) begin
        valid_r <= nb_valid;
      end
    end
  end

  // tag, meaningful only while valid
  always_ff @(posedge clk) begin
    if (ctl.set_tag) begin
      tag_r <= key;
    end else if (ctl.take) begin
      tag_r <= nb_tag;
    end
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign bufn  = bufn_r;
  assign match = valid_r && (tag_r == key);

endmodule

>>> hw/rtl/lru_block_read_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_read_cache_tags
// Tag and recency keeper of a small fully associative cache of file blocks.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   op, position, request_length
//   out      output     out_valid/out_stall status, buffer_index,
//                                           block_offset, byte_count
//   cfg      input      cfg_valid/cfg_ready index, data
//
// One word per cycle while the result is not stalled: all slot cells compare
// in parallel and the chain shifts in the same cycle, so each word's result
// appears in the cycle after it is taken, from a single output register.
// Synchronous reset empties every slot and gives slot i buffer i.
// A stalled result holds the output register; a new word is taken in the
// cycle the held result leaves.
// ----------------------------------------------------------------------------
module lru_block_read_cache_tags
  import lbrc_pkg::*;
#(
  parameter int NSLOTS = NSLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [POS_W-1:0]     in_position,
  input  logic [LEN_W-1:0]     in_request_length,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [BIDX_W-1:0]    out_buffer_index,
  output logic [OFFS_W-1:0]    out_block_offset,
  output logic [CNT_W-1:0]     out_byte_count,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int BUF_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int IDX_W = BUF_W;
  localparam int N_W   = $clog2(NSLOTS + 1);

  // configuration registers
  logic [LG_W-1:0]    block_log2_r;
  logic [POS_W-1:0]   file_size_r;
  logic [SLOTS_W-1:0] slots_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_log2_r <= LG_RESET;
      file_size_r  <= FSIZE_RESET;
      slots_r      <= SLOTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLOCK_LOG2: block_log2_r <= cfg_data[LG_W-1:0];
        CFG_FILE_SIZE:  file_size_r  <= cfg_data[POS_W-1:0];
        CFG_SLOTS:      slots_r      <= cfg_data[SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  // output register and handshake
  logic               out_valid_r;
  status_t            status_r;
  logic [BIDX_W-1:0]  bidx_r;
  logic [OFFS_W-1:0]  offs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               acc;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  // effective block size and slot count
  logic [LG_W-1:0] lg_eff;
  logic [N_W-1:0]  n_eff;
  logic [N_W-1:0]  n_m1;

  always_comb begin
    if (block_log2_r < LG_MIN)      lg_eff = LG_MIN;
    else if (block_log2_r > LG_MAX) lg_eff = LG_MAX;
    else                            lg_eff = block_log2_r;
    if (slots_r == '0)                   n_eff = N_W'(1);
    else if (32'(slots_r) > NSLOTS)      n_eff = N_W'(NSLOTS);
    else                                 n_eff = N_W'(slots_r);
    n_m1 = n_eff - N_W'(1);
  end

  // block number, offset and byte limits
  logic [TAG_W-1:0]  key;
  logic [OFFS_W-1:0] offs_mask;
  logic [OFFS_W-1:0] offs;
  logic [CNT_W-1:0]  room;
  logic [POS_W-1:0]  left;
  logic [CNT_W-1:0]  cnt_a;
  logic [CNT_W-1:0]  cnt;
  logic              eof;

  always_comb begin
    key       = TAG_W'(in_position >> lg_eff);
    offs_mask = OFFS_W'((CNT_W'(1) << lg_eff) - CNT_W'(1));
    offs      = in_position[OFFS_W-1:0] & offs_mask;
    room      = (CNT_W'(1) << lg_eff) - {1'b0, offs};
    left      = file_size_r - in_position;
    eof       = (in_position >= file_size_r);
    if (in_request_length < LEN_W'(room)) cnt_a = CNT_W'(in_request_length);
    else                                  cnt_a = room;
    if (left < POS_W'(cnt_a)) cnt = left[CNT_W-1:0];
    else                      cnt = cnt_a;
  end

  // cell chain
  logic              cv    [NSLOTS];
  logic [TAG_W-1:0]  ct    [NSLOTS];
  logic [BUF_W-1:0]  cb    [NSLOTS];
  logic              cm    [NSLOTS];
  cell_ctl_t         ctl   [NSLOTS];
  logic              nbv   [NSLOTS];
  logic [TAG_W-1:0]  nbt   [NSLOTS];
  logic [BUF_W-1:0]  nbb   [NSLOTS];

  // first active matching slot
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (!hit && cm[i] && (N_W'(i) < n_eff)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // rotation control
  logic             is_inv;
  logic             is_fill;
  logic             is_look;
  logic [IDX_W-1:0] rot_k;
  logic             rot_en;

  assign is_inv  = in_op[1];
  assign is_fill = (in_op == OP_FILL);
  assign is_look = (in_op == OP_LOOKUP);
  assign rot_k   = is_fill ? n_m1[IDX_W-1:0] : hit_idx;
  assign rot_en  = acc && ((is_fill && cv[0] && (n_eff > N_W'(1))) ||
                           (is_look && !eof && hit));

  always_comb begin
    for (int i = 0; i < NSLOTS; i++) begin
      ctl[i].take    = rot_en && (IDX_W'(i) <= rot_k);
      ctl[i].set_tag = acc && is_fill && (i == 0);
      ctl[i].clear   = acc && is_inv;
      if (i == 0) begin
        nbv[i] = cv[rot_k];
        nbt[i] = ct[rot_k];
        nbb[i] = cb[rot_k];
      end else begin
        nbv[i] = cv[(i > 0) ? i - 1 : 0];
        nbt[i] = ct[(i > 0) ? i - 1 : 0];
        nbb[i] = cb[(i > 0) ? i - 1 : 0];
      end
    end
  end

  for (genvar g = 0; g < NSLOTS; g++) begin : g_cell
    lbrc_cell #(
      .BUF_W     (BUF_W),
      .RESET_BUF (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[g]),
      .key      (key),
      .nb_valid (nbv[g]),
      .nb_tag   (nbt[g]),
      .nb_bufn  (nbb[g]),
      .valid    (cv[g]),
      .tag      (ct[g]),
      .bufn     (cb[g]),
      .match    (cm[g])
    );
  end

  // buffer that ends up at the front
  logic [BIDX_W-1:0] front_buf;
  assign front_buf = BIDX_W'(rot_en ? nbb[0] : cb[0]);

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (is_inv) begin
        status_r <= ST_INVALIDATED;
        bidx_r   <= '0;
        offs_r   <= '0;
        cnt_r    <= '0;
      end else if (is_fill) begin
        status_r <= ST_FILLED;
        bidx_r   <= front_buf;
        offs_r   <= '0;
        cnt_r    <= '0;
      end else if (eof) begin
        status_r <= ST_EOF;
        bidx_r   <= '0;
        offs_r   <= '0;
        cnt_r    <= '0;
      end else if (!hit) begin
        status_r <= ST_MISS;
        bidx_r   <= '0;
        offs_r   <= '0;
        cnt_r    <= '0;
      end else begin
        status_r <= ST_HIT;
        bidx_r   <= front_buf;
        offs_r   <= offs;
        cnt_r    <= cnt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_buffer_index = bidx_r;
  assign out_block_offset = offs_r;
  assign out_byte_count   = cnt_r;

endmodule

>>> sim/lru_block_read_cache_tags_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_read_cache_tags_tb
// Self-checking bench for the block read cache tag keeper.
//
// A driver sends request words in bursts from a backlog. A monitor takes
// result words while the receiver stalls on its own pattern. Each accepted
// request runs through a local tag/recency model whose result is queued.
// Each result word is matched field by field against the oldest queued
// result. Configuration changes only between phases, once the block has
// drained. The run starts with a directed set, then random phases that
// reach the register extremes.
// ----------------------------------------------------------------------------
module lru_block_read_cache_tags_tb;
  import lbrc_pkg::*;

  localparam int NSLOTS = NSLOTS_DEF;
  localparam int HOT_N  = 6;
  localparam logic [OP_W-1:0]  OP_INVAL = 2'd2;
  localparam logic [OP_W-1:0]  OP_UNDEF = 2'd3;
  localparam logic [POS_W-1:0] POS_MAX  = 40'hFF_FFFF_FFFF;
  localparam logic [LEN_W-1:0] LEN_MAX  = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } tag_req_t;

  typedef struct {
    status_t           status;
    logic [BIDX_W-1:0] bidx;
    logic [OFFS_W-1:0] offs;
    logic [CNT_W-1:0]  cnt;
  } tag_result_t;

  // clock, reset and block ports
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op = '0;
  logic [POS_W-1:0]     in_position = '0;
  logic [LEN_W-1:0]     in_request_length = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [BIDX_W-1:0]    out_buffer_index;
  logic [OFFS_W-1:0]    out_block_offset;
  logic [CNT_W-1:0]     out_byte_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // model copy of the registers and the slot chain
  logic [LG_W-1:0]    m_lg;
  logic [POS_W-1:0]   m_fsize;
  logic [SLOTS_W-1:0] m_slots;
  logic               m_valid [NSLOTS];
  logic [TAG_W-1:0]   m_tag   [NSLOTS];
  logic [BIDX_W-1:0]  m_buf   [NSLOTS];

  // block numbers that random requests aim at
  logic [TAG_W-1:0] hot_tags [HOT_N];

  tag_req_t    req_backlog [$];
  tag_result_t tag_results_due [$];
  tag_req_t    staged;
  tag_result_t want;
  int          fail_count = 0;
  int          taken_count = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  int          hold_stage = 0;
  int          mode_left = 0;
  int          stall_mode = 0;
  logic [7:0]  pat_ctr = '0;

  lru_block_read_cache_tags #(
    .NSLOTS(NSLOTS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_position       (in_position),
    .in_request_length (in_request_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_buffer_index  (out_buffer_index),
    .out_block_offset  (out_block_offset),
    .out_byte_count    (out_byte_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // block size with out-of-range settings clamped
  function automatic int unsigned eff_lg();
    if (m_lg < LG_MIN) return 32'(LG_MIN);
    if (m_lg > LG_MAX) return 32'(LG_MAX);
    return 32'(m_lg);
  endfunction

  // move slot k to the front, slots above it shift down one
  function automatic void bring_front(int unsigned k);
    logic              v;
    logic [TAG_W-1:0]  t;
    logic [BIDX_W-1:0] b;
    int unsigned       i;
    v = m_valid[k];
    t = m_tag[k];
    b = m_buf[k];
    for (i = k; i > 0; i--) begin
      m_valid[i] = m_valid[i-1];
      m_tag[i]   = m_tag[i-1];
      m_buf[i]   = m_buf[i-1];
    end
    m_valid[0] = v;
    m_tag[0]   = t;
    m_buf[0]   = b;
  endfunction

  // result of one request, updating the model chain
  function automatic tag_result_t next_tag_result(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                  logic [LEN_W-1:0] len);
    tag_result_t r;
    int unsigned lg, n, hit, i;
    logic [63:0] bs, blk, offs, cnt, room;
    lg = eff_lg();
    n = (m_slots < 1) ? 1 : (m_slots > NSLOTS) ? NSLOTS : 32'(m_slots);
    bs = 64'd1 << lg;
    blk = {24'd0, pos} >> lg;
    r.status = ST_INVALIDATED;
    r.bidx = '0;
    r.offs = '0;
    r.cnt = '0;
    if (op == OP_FILL) begin
      // reuse an empty front slot, else recycle the least recent buffer
      if (m_valid[0] && n > 1) bring_front(n - 1);
      m_valid[0] = 1'b1;
      m_tag[0] = blk[TAG_W-1:0];
      r.bidx = m_buf[0];
      r.status = ST_FILLED;
    end else if (op == OP_LOOKUP) begin
      if (pos >= m_fsize) begin
        r.status = ST_EOF;
      end else begin
        // nearest matching slot to the front wins
        hit = n;
        for (i = 0; i < n; i++) begin
          if (hit == n && m_valid[i] && m_tag[i] == blk[TAG_W-1:0]) hit = i;
        end
        if (hit == n) begin
          r.status = ST_MISS;
        end else begin
          bring_front(hit);
          offs = {24'd0, pos} & (bs - 1);
          cnt = bs - offs;
          if ({33'd0, len} < cnt) cnt = {33'd0, len};
          room = {24'd0, m_fsize} - {24'd0, pos};
          if (cnt > room) cnt = room;
          r.bidx = m_buf[0];
          r.offs = offs[OFFS_W-1:0];
          r.cnt = cnt[CNT_W-1:0];
          r.status = ST_HIT;
        end
      end
    end else begin
      for (i = 0; i < NSLOTS; i++) m_valid[i] = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(string what, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val, act_val);
    end
  endtask

  // request driver: bursts from the backlog with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        tag_results_due.push_back(next_tag_result(in_op, in_position, in_request_length));
        taken_count <= taken_count + 1;
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_backlog.size() > 0) begin
        staged = req_backlog.pop_front();
        in_valid <= 1'b1;
        in_op <= staged.op;
        in_position <= staged.pos;
        in_request_length <= staged.len;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: long hold-offs once the flow is going, else a changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_stage <= 0;
      mode_left <= 0;
      stall_mode <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_stage < 2 && taken_count >= ((hold_stage == 0) ? 300 : 700)) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_stage <= hold_stage + 1;
    end else begin
      pat_ctr <= pat_ctr + 1'b1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(16, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 25);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= pat_ctr[2] ^ pat_ctr[0];
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tag_results_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 out_status);
      end else begin
        want = tag_results_due.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("buffer_index", 64'(want.bidx), 64'(out_buffer_index));
        check_field("block_offset", 64'(want.offs), 64'(out_block_offset));
        check_field("byte_count", 64'(want.cnt), 64'(out_byte_count));
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BLOCK_LOG2: m_lg = val[LG_W-1:0];
      CFG_FILE_SIZE:  m_fsize = val[POS_W-1:0];
      CFG_SLOTS:      m_slots = val[SLOTS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [LG_W-1:0] lg, logic [POS_W-1:0] fsize,
                            logic [SLOTS_W-1:0] slots);
    cfg_write(CFG_BLOCK_LOG2, {35'd0, lg});
    cfg_write(CFG_FILE_SIZE, fsize);
    cfg_write(CFG_SLOTS, {37'd0, slots});
  endtask

  // wait until every word is out and the block has gone quiet
  task automatic settle();
    do @(posedge clk);
    while (req_backlog.size() != 0 || in_valid || tag_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
    tag_req_t r;
    r.op = op;
    r.pos = pos;
    r.len = len;
    req_backlog.push_back(r);
  endtask

  // one random phase: mostly fills and lookups on a few hot blocks, some noise
  task automatic run_random(logic [LG_W-1:0] lg, logic [POS_W-1:0] fsize,
                            logic [SLOTS_W-1:0] slots, int count);
    tag_req_t    r;
    int unsigned lgv, kind;
    int          i;
    logic [63:0] bs, last_blk, base, offs;
    set_config(lg, fsize, slots);
    lgv = eff_lg();
    bs = 64'd1 << lgv;
    last_blk = (m_fsize == 0) ? 64'd0 : ({24'd0, m_fsize} - 1) >> lgv;
    for (i = 0; i < HOT_N; i++) begin
      if (i == 0 || m_fsize == 0) hot_tags[i] = TAG_W'(rand64());
      else if (i == 1) hot_tags[i] = last_blk[TAG_W-1:0];
      else hot_tags[i] = TAG_W'(rand64() % (last_blk + 1));
    end
    for (i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      base = {28'd0, hot_tags[$urandom_range(0, HOT_N - 1)]} << lgv;
      case ($urandom_range(0, 3))
        0: offs = 64'd0;
        1: offs = bs - 1;
        default: offs = rand64() & (bs - 1);
      endcase
      r.pos = POS_W'(base | offs);
      case ($urandom_range(0, 4))
        0: r.len = '0;
        1: r.len = LEN_W'($urandom_range(1, 64));
        2: r.len = LEN_MAX;
        3: r.len = LEN_W'($urandom_range(1, 32'(bs)));
        default: r.len = LEN_W'($urandom);
      endcase
      if (kind < 25) begin
        r.op = OP_FILL;
      end else if (kind < 70) begin
        r.op = OP_LOOKUP;
      end else if (kind < 75) begin
        // close to end of file
        r.op = OP_LOOKUP;
        if (m_fsize > 64) r.pos = m_fsize - 1 - POS_W'($urandom_range(0, 40));
      end else if (kind < 78) begin
        r.op = $urandom_range(0, 1) ? OP_INVAL : OP_UNDEF;
      end else begin
        r.op = OP_W'($urandom_range(0, 3));
        r.pos = POS_W'(rand64());
        r.len = LEN_W'($urandom);
      end
      req_backlog.push_back(r);
    end
    settle();
  endtask

  // main sequence
  initial begin
    m_lg = LG_RESET;
    m_fsize = FSIZE_RESET;
    m_slots = SLOTS_RESET;
    for (int i = 0; i < NSLOTS; i++) begin
      m_valid[i] = 1'b0;
      m_tag[i] = '0;
      m_buf[i] = BIDX_W'(i);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty file, so lookups end at end of file
    push_req(OP_LOOKUP, 40'd0, 31'd100);
    push_req(OP_FILL, 40'd0, 31'd0);
    push_req(OP_LOOKUP, 40'd0, 31'd0);
    push_req(OP_INVAL, 40'd0, 31'd0);
    settle();

    // smallest blocks, largest file, all slots
    set_config(5'd4, POS_MAX, 3'd4);
    push_req(OP_FILL, 40'd0, 31'd0);
    push_req(OP_LOOKUP, 40'd0, 31'd0);
    push_req(OP_LOOKUP, 40'd5, LEN_MAX);
    push_req(OP_FILL, 40'd16, 31'd0);
    push_req(OP_FILL, 40'd32, 31'd0);
    push_req(OP_FILL, 40'd48, 31'd0);
    push_req(OP_FILL, 40'd64, 31'd0);
    push_req(OP_LOOKUP, 40'd0, 31'd8);
    push_req(OP_LOOKUP, 40'd31, 31'd1);
    // same block twice in the chain
    push_req(OP_FILL, 40'd16, 31'd0);
    push_req(OP_LOOKUP, 40'd20, 31'd3);
    push_req(OP_LOOKUP, POS_MAX, LEN_MAX);
    // fill past end of file, then a lookup cut by end of file
    push_req(OP_FILL, POS_MAX, 31'd0);
    push_req(OP_LOOKUP, POS_MAX - 40'd2, LEN_MAX);
    push_req(OP_UNDEF, 40'd0, 31'd0);
    push_req(OP_LOOKUP, 40'd16, 31'd4);
    settle();

    // largest blocks, single slot
    set_config(5'd20, 40'd3_000_000, 3'd1);
    push_req(OP_FILL, 40'd0, 31'd0);
    push_req(OP_FILL, 40'h10_0007, 31'd0);
    push_req(OP_LOOKUP, 40'd3, 31'd10);
    push_req(OP_LOOKUP, 40'h10_0005, LEN_MAX);
    push_req(OP_LOOKUP, 40'd2_999_999, 31'd10);
    settle();

    // random phases, block size and slot count change with slots still tagged
    run_random(5'd4, POS_MAX, 3'd4, 100);
    run_random(5'd20, POS_MAX, 3'd4, 90);
    run_random(5'd12, POS_W'(rand64()), 3'd2, 90);
    run_random(5'd0, POS_W'(rand64()), 3'd0, 90);
    run_random(5'd31, 40'd5_000_000, 3'd7, 90);
    run_random(LG_W'($urandom_range(0, 31)), POS_W'($urandom_range(1, 24'hFF_FFFF)),
               3'd3, 90);
    run_random(5'd8, 40'd0, 3'd4, 40);
    run_random(5'd3, POS_MAX, 3'd5, 90);
    repeat (3) run_random(LG_W'($urandom_range(0, 31)), POS_W'(rand64()),
                          SLOTS_W'($urandom_range(0, 7)), 65);

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> lru_block_read_cache_tags.f
hw/rtl/lbrc_pkg.sv
hw/rtl/lbrc_cell.sv
hw/rtl/lru_block_read_cache_tags.sv
sim/lru_block_read_cache_tags_tb.sv
